[src/poe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poe_pkg: shared types and codes of the page owner table engine
// Page entry, command and response payloads, operation codes.
// ----------------------------------------------------------------------------
package poe_pkg;

	// operation codes
	localparam logic [2:0] FN_CHECK = 3'd0;
	localparam logic [2:0] FN_SET   = 3'd1;
	localparam logic [2:0] FN_FIND  = 3'd2;
	localparam logic [2:0] FN_CLAIM = 3'd3;
	localparam logic [2:0] FN_FREE  = 3'd4;
	localparam logic [2:0] FN_COUNT = 3'd5;

	// configuration register indexes
	localparam logic CFG_PAGES_IN_USE = 1'b0;
	localparam logic CFG_FREE_KEY     = 1'b1;

	localparam logic [7:0]  KEY_RESET   = 8'hFF;
	localparam logic [10:0] PAGES_RESET = 11'd1024;

	typedef struct packed {
		logic [7:0] key;
		logic [7:0] access;
	} page_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [19:0] address;
		logic [20:0] byte_count;
		logic [9:0]  first_page;
		logic [10:0] run_length;
		logic [7:0]  owner_key;
		logic [7:0]  access_bits;
		logic [7:0]  process_key;
	} cmd_t;

	typedef struct packed {
		logic        ok;
		logic [9:0]  page_index;
		logic [10:0] owned_count;
	} rsp_t;

endpackage

[src/poe_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poe_cell: one page entry of the rotating table
// Holds key and permissions of one page and passes them on when shifting.
// ----------------------------------------------------------------------------
module poe_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  poe_pkg::page_t nbr,
	output poe_pkg::page_t page
);

	poe_pkg::page_t page_q;

	// entry resets to a free page with no access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q.key    <= poe_pkg::KEY_RESET;
			page_q.access <= 8'h00;
		end else if (shift) begin
			page_q <= nbr;
		end
	end

	assign page = page_q;

endmodule

[src/poe_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poe_chain: ring of page cells
// Cell 0 is the head seen by the controller; the tail takes the updated entry.
// ----------------------------------------------------------------------------
module poe_chain #(
	parameter int PAGES = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  poe_pkg::page_t tail,
	output poe_pkg::page_t head
);

	poe_pkg::page_t cell_out [PAGES];

	// each cell loads its upper neighbor; the last loads the tail
	for (genvar k = 0; k < PAGES; k++) begin : g_cell
		poe_pkg::page_t nbr;
		if (k == PAGES - 1) begin : g_last
			assign nbr = tail;
		end else begin : g_mid
			assign nbr = cell_out[k + 1];
		end
		poe_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.nbr    (nbr),
			.page   (cell_out[k])
		);
	end

	assign head = cell_out[0];

endmodule

[src/page_owner_table_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_owner_table_engine: first-fit page allocator with key protection
// The table rotates through a ring of cells; the head entry is tested and
// rewritten once per cycle as it passes to the tail.
// ----------------------------------------------------------------------------
//  channel  | signals                     | direction
//  cmd      | cmd_valid cmd_stall cmd     | in
//  rsp      | rsp_valid rsp_stall rsp     | out
//  cfg      | cfg_we cfg_index cfg_wdata  | in
//
// Every command walks the full ring once, as the ring has a single head
// port. A claim with a hit walks it a second time.
// Reset loads every entry with key 255 and no access; no clearing pass.
// A stalled response holds the block in its done state until taken.
module page_owner_table_engine #(
	parameter int PAGES      = 1024,
	parameter int PAGE_BYTES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  poe_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output poe_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [10:0]   cfg_wdata
);

	localparam int PW  = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int CW  = $clog2(PAGES + 1);
	localparam int LW  = ((CW > 12) ? CW : 12) + 1;
	localparam int BW0 = $clog2(PAGES) + $clog2(PAGE_BYTES) + 2;
	localparam int BW  = (BW0 > 23) ? BW0 : 23;
	localparam logic [PW-1:0] LAST_POS = PW'(PAGES - 1);
	localparam logic [BW-1:0] PB       = BW'(PAGE_BYTES);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_CLAIM = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t         state_q;
	poe_pkg::cmd_t  cmd_q;
	logic [10:0]    pages_in_use_q;
	logic [7:0]     free_key_q;
	logic [PW-1:0]  pos_q;
	logic [BW-1:0]  base_q;
	logic [BW-1:0]  last_q;
	logic [LW-1:0]  lo_q, hi_q;
	logic           set_ok_q;
	logic [CW-1:0]  run_q;
	logic [PW-1:0]  run_start_q;
	logic           found_q;
	logic [PW-1:0]  found_idx_q;
	logic [10:0]    cnt_q;
	logic           seen_p1_q, seen_p2_q, bad_q;
	logic           rsp_valid_q;
	poe_pkg::rsp_t  rsp_q;

	poe_pkg::page_t head, tail;
	logic           shift;
	logic [LW-1:0]  n_live, pos_w;
	logic           live, in_win, key_match, is_free;
	logic [BW-1:0]  addr_w, base_end;
	logic           in_p1, in_p2, in_rng, pg_bad;
	logic [CW-1:0]  run_nxt;
	logic           hit;
	logic           end_pass;
	logic           rsp_free;
	poe_pkg::rsp_t  result;

	assign shift = (state_q == ST_WALK) || (state_q == ST_CLAIM);

	poe_chain #(.PAGES(PAGES)) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (shift),
		.tail   (tail),
		.head   (head)
	);

	// per-page conditions at the head
	assign n_live    = (LW'(pages_in_use_q) > LW'(PAGES)) ? LW'(PAGES) : LW'(pages_in_use_q);
	assign pos_w     = LW'(pos_q);
	assign live      = pos_w < n_live;
	assign in_win    = live && (pos_w >= lo_q) && (pos_w < hi_q);
	assign key_match = head.key == cmd_q.owner_key;
	assign is_free   = head.key == free_key_q;
	assign addr_w    = BW'(cmd_q.address);
	assign base_end  = base_q + PB - BW'(1);
	assign in_p1     = (base_q <= addr_w) && (addr_w <= base_end);
	assign in_p2     = (base_q <= last_q) && (last_q <= base_end);
	assign in_rng    = (cmd_q.byte_count != 21'd0) && (base_q <= last_q) && (base_end >= addr_w);
	assign pg_bad    = !((head.key == 8'h00) || (head.key == cmd_q.process_key)) ||
	                   ((head.access & cmd_q.access_bits) != cmd_q.access_bits);
	assign run_nxt   = run_q + CW'(1);
	assign hit       = live && !found_q && is_free &&
	                   (LW'(run_nxt) == LW'(cmd_q.run_length));
	assign end_pass  = pos_q == LAST_POS;

	// entry written back at the tail
	always_comb begin
		tail = head;
		if (state_q == ST_CLAIM) begin
			if (in_win) begin
				tail.key    = cmd_q.owner_key;
				tail.access = cmd_q.access_bits;
			end
		end else begin
			case (cmd_q.func)
				poe_pkg::FN_SET: begin
					if (in_win) begin
						tail.key    = cmd_q.owner_key;
						tail.access = cmd_q.access_bits;
					end
				end
				poe_pkg::FN_FREE: begin
					if (live && key_match) begin
						tail.key    = free_key_q;
						tail.access = 8'h00;
					end
				end
				default: ;
			endcase
		end
	end

	// result assembly
	always_comb begin
		result = '0;
		case (cmd_q.func)
			poe_pkg::FN_CHECK: begin
				if (!seen_p1_q) result.ok = 1'b0;
				else if (cmd_q.byte_count == 21'd0) result.ok = 1'b1;
				else if (!seen_p2_q) result.ok = 1'b0;
				else if (cmd_q.process_key == 8'h00) result.ok = 1'b1;
				else result.ok = !bad_q;
			end
			poe_pkg::FN_SET: result.ok = set_ok_q;
			poe_pkg::FN_FIND, poe_pkg::FN_CLAIM: begin
				result.ok         = found_q;
				result.page_index = found_q ? 10'(found_idx_q) : 10'd0;
			end
			poe_pkg::FN_FREE: result.ok = 1'b1;
			poe_pkg::FN_COUNT: begin
				result.ok          = 1'b1;
				result.owned_count = cnt_q;
			end
			default: ;
		endcase
	end

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = state_q != ST_IDLE;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_in_use_q <= poe_pkg::PAGES_RESET;
			free_key_q     <= poe_pkg::KEY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				poe_pkg::CFG_PAGES_IN_USE: pages_in_use_q <= cfg_wdata;
				poe_pkg::CFG_FREE_KEY:     free_key_q     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			found_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_WALK;
						pos_q   <= '0;
						found_q <= 1'b0;
					end
				end
				ST_WALK: begin
					pos_q <= end_pass ? '0 : pos_q + PW'(1);
					if (hit) found_q <= 1'b1;
					if (end_pass) begin
						if (cmd_q.func == poe_pkg::FN_CLAIM && (found_q || hit))
							state_q <= ST_CLAIM;
						else
							state_q <= ST_DONE;
					end
				end
				ST_CLAIM: begin
					pos_q <= end_pass ? '0 : pos_q + PW'(1);
					if (end_pass) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// response valid: raised on leaving done, dropped on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// command capture and walk accumulators
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q     <= cmd;
			last_q    <= BW'(cmd.address) + BW'(cmd.byte_count) - BW'(1);
			lo_q      <= LW'(cmd.first_page);
			hi_q      <= LW'(cmd.first_page) + LW'(cmd.run_length);
			set_ok_q  <= (LW'(cmd.first_page) + LW'(cmd.run_length)) <= n_live;
			base_q    <= '0;
			run_q     <= '0;
			cnt_q     <= '0;
			seen_p1_q <= 1'b0;
			seen_p2_q <= 1'b0;
			bad_q     <= 1'b0;
		end else if (state_q == ST_WALK) begin
			base_q <= base_q + PB;
			if (live && in_p1) seen_p1_q <= 1'b1;
			if (live && in_p2) seen_p2_q <= 1'b1;
			if (live && in_rng && pg_bad) bad_q <= 1'b1;
			if (live && key_match) cnt_q <= cnt_q + 11'd1;
			if (live && !found_q) begin
				if (is_free) begin
					run_q <= run_nxt;
					if (run_q == '0) run_start_q <= pos_q;
					if (hit) found_idx_q <= (run_q == '0) ? pos_q : run_start_q;
				end else begin
					run_q <= '0;
				end
			end
			// claim window for the second pass
			if (end_pass) begin
				lo_q <= LW'(hit ? ((run_q == '0) ? pos_q : run_start_q) : found_idx_q);
				hi_q <= LW'(hit ? ((run_q == '0) ? pos_q : run_start_q) : found_idx_q) +
				        LW'(cmd_q.run_length);
			end
		end
		if (state_q == ST_DONE && rsp_free) rsp_q <= result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a command is only taken while the ring is parked
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_CLAIM) |-> cmd_stall)
		else $error("command accepted during walk");

	// claim pass only follows a hit of a claim command
	a_claim_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLAIM) |-> (found_q && cmd_q.func == poe_pkg::FN_CLAIM))
		else $error("claim pass without found run");

	// ring is parked at page 0 whenever idle
	a_parked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pos_q == '0))
		else $error("ring not parked at page 0");

	// a response is loaded only on leaving the done state
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("response raised outside done state");

endmodule
